// ===== hw/rtl/pgcc_pkg.sv =====
// Package for the pairwise genotype conflict counter.
// Holds field widths, default sizes, operation codes, the sequencer state type
// and the opposing-homozygote test. No dependencies.
package pgcc_pkg;

    localparam int IND_W  = 6;   // individual / partner field width
    localparam int GENO_W = 2;   // genotype field width
    localparam int CFG_W  = 7;   // individual_count register width
    localparam int PAIR_W = 16;  // pair_count field width

    localparam int DEF_MAX_INDIVIDUALS = 64;
    localparam int DEF_COUNT_WIDTH     = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic OP_GENOTYPE = 1'b0;
    localparam logic OP_READ     = 1'b1;

    localparam logic [GENO_W-1:0] GENO_HOM_LOW  = 2'd0;
    localparam logic [GENO_W-1:0] GENO_HOM_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_READ
    } t_state;

    // true when one genotype is homozygous low and the other homozygous high
    function automatic logic opposing(input logic [GENO_W-1:0] a,
                                      input logic [GENO_W-1:0] b);
        return ((a == GENO_HOM_LOW) && (b == GENO_HOM_HIGH)) ||
               ((a == GENO_HOM_HIGH) && (b == GENO_HOM_LOW));
    endfunction

endpackage

// ===== hw/rtl/pairwise_genotype_conflict_counter.sv =====
// Pairwise genotype conflict counter: top level with sequencer, genotype store
// and pair counter store. Depends on pgcc_pkg.
//
//  channel   | ports                                                 | handshake
//  ----------+-------------------------------------------------------+---------------------
//  item in   | i_operation, i_individual, i_genotype, i_partner      | start && !busy
//  result    | o_pair_count                                          | o_valid, one cycle
//  config    | i_cfg_wdata (individual_count)                        | i_cfg_we
//
// Sequencing: a genotype item for individual i holds busy while it sweeps the
// lower individuals; one counter read-modify-write per lower individual through the
// single counter memory port pair, with read and update overlapped, plus a final
// step for the last update. Individual 0 and ignored individuals do not raise
// busy. A read item holds busy in the read state and its result shows in that
// state. After reset every counter memory address (MAX_INDIVIDUALS rounded up to
// a power of two, squared) is cleared with busy high; config writes are taken
// meanwhile. Results cannot be stalled by the receiver.
module pairwise_genotype_conflict_counter #(
    parameter int MAX_INDIVIDUALS = pgcc_pkg::DEF_MAX_INDIVIDUALS,
    parameter int COUNT_WIDTH     = pgcc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item in
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_operation,
    input  logic [pgcc_pkg::IND_W-1:0]   i_individual,
    input  logic [pgcc_pkg::GENO_W-1:0]  i_genotype,
    input  logic [pgcc_pkg::IND_W-1:0]   i_partner,
    // result
    output logic                         o_valid,
    output logic [pgcc_pkg::PAIR_W-1:0]  o_pair_count,
    // config
    input  logic                         i_cfg_we,
    input  logic [pgcc_pkg::CFG_W-1:0]   i_cfg_wdata
);

    // index width for one individual; compare width holds MAX_INDIVIDUALS itself
    localparam int IW      = (MAX_INDIVIDUALS > 1) ? $clog2(MAX_INDIVIDUALS) : 1;
    localparam int CW_BASE = IW + 1;
    localparam int CW      = (CW_BASE > pgcc_pkg::CFG_W) ? CW_BASE : pgcc_pkg::CFG_W;
    localparam int AW      = 2 * IW;          // pair counter address {low, high}
    localparam int CDEPTH  = 1 << AW;

    localparam logic [CW-1:0]          MAX_C     = CW'(MAX_INDIVIDUALS);
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

    // ---------------------------------------------------------------- state
    pgcc_pkg::t_state r_state, n_state;

    logic [pgcc_pkg::CFG_W-1:0] r_individual_count;
    logic [AW-1:0]              r_clr, n_clr;
    logic                       r_pend, n_pend;      // a read is in flight
    logic [IW-1:0]              r_j, n_j;            // next lower individual
    logic [IW-1:0]              r_pj, n_pj;          // individual of the read in flight
    logic [IW-1:0]              r_i, n_i;            // individual being compared
    logic [pgcc_pkg::GENO_W-1:0] r_geno, n_geno;
    logic                       r_pair_ok, n_pair_ok;

    // ---------------------------------------------------------------- memories
    logic [pgcc_pkg::GENO_W-1:0] geno_mem [MAX_INDIVIDUALS];
    logic [COUNT_WIDTH-1:0]      cnt_mem  [CDEPTH];
    logic [pgcc_pkg::GENO_W-1:0] r_gq;
    logic [COUNT_WIDTH-1:0]      r_cq;

    logic                        g_we;
    logic [IW-1:0]               g_waddr;
    logic                        cnt_we;
    logic [AW-1:0]               cnt_waddr;
    logic [AW-1:0]               cnt_raddr;
    logic [COUNT_WIDTH-1:0]      cnt_wdata;

    // ---------------------------------------------------------------- decode
    logic                        accept;
    logic [CW-1:0]               eff_count;
    logic                        ind_ok;
    logic [pgcc_pkg::IND_W-1:0]  lo, hi;

    assign accept    = start && !busy;
    assign eff_count = (CW'(r_individual_count) > MAX_C) ? MAX_C
                                                         : CW'(r_individual_count);
    assign ind_ok    = CW'(i_individual) < eff_count;
    assign lo        = (i_individual < i_partner) ? i_individual : i_partner;
    assign hi        = (i_individual < i_partner) ? i_partner : i_individual;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_individual_count <= pgcc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_individual_count <= i_cfg_wdata;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pgcc_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_pj      <= n_pj;
        r_i       <= n_i;
        r_geno    <= n_geno;
        r_pair_ok <= n_pair_ok;
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_pend    = 1'b0;
        n_j       = r_j;
        n_pj      = r_pj;
        n_i       = r_i;
        n_geno    = r_geno;
        n_pair_ok = r_pair_ok;
        g_we      = 1'b0;
        g_waddr   = IW'(i_individual);
        cnt_we    = 1'b0;
        cnt_waddr = {r_pj, r_i};
        cnt_wdata = (r_cq == COUNT_TOP) ? r_cq : r_cq + 1'b1;
        cnt_raddr = {r_j, r_i};
        busy      = 1'b1;
        o_valid   = 1'b0;

        case (r_state)
            pgcc_pkg::ST_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                cnt_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = pgcc_pkg::ST_IDLE;
                end
            end
            pgcc_pkg::ST_IDLE: begin
                busy      = 1'b0;
                cnt_raddr = {IW'(lo), IW'(hi)};
                if (accept) begin
                    if (i_operation == pgcc_pkg::OP_READ) begin
                        n_pair_ok = (lo != hi) && (CW'(hi) < MAX_C);
                        n_state   = pgcc_pkg::ST_READ;
                    end else if (ind_ok) begin
                        // lower individuals are only read, so the store can
                        // take the new genotype right away
                        g_we   = 1'b1;
                        n_i    = IW'(i_individual);
                        n_geno = i_genotype;
                        n_j    = '0;
                        if (i_individual != '0) begin
                            n_state = pgcc_pkg::ST_SWEEP;
                        end
                    end
                end
            end
            pgcc_pkg::ST_SWEEP: begin
                // issue read of pair {j, i} while updating the previous one
                if (r_pend && pgcc_pkg::opposing(r_geno, r_gq)) begin
                    cnt_we = 1'b1;
                end
                if (r_j != r_i) begin
                    n_pend = 1'b1;
                    n_pj   = r_j;
                    n_j    = r_j + 1'b1;
                end else begin
                    n_state = pgcc_pkg::ST_IDLE;
                end
            end
            pgcc_pkg::ST_READ: begin
                o_valid = 1'b1;
                n_state = pgcc_pkg::ST_IDLE;
            end
            default: begin
                n_state = pgcc_pkg::ST_IDLE;
            end
        endcase
    end

    // COUNT_WIDTH may be narrower or wider than the result field
    assign o_pair_count = r_pair_ok ? pgcc_pkg::PAIR_W'(r_cq) : '0;

    // ---------------------------------------------------------------- storage
    always_ff @(posedge i_clk) begin
        if (g_we) begin
            geno_mem[g_waddr] <= i_genotype;
        end
        r_gq <= geno_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cq <= cnt_mem[cnt_raddr];
    end

`ifndef SYNTH
    // a result only follows a read item taken in the cycle before
    a_valid_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept && (i_operation == pgcc_pkg::OP_READ)))
        else $error("result without a read item");

    // the lower index never passes the compared individual
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pgcc_pkg::ST_SWEEP) |-> ((r_j < r_i) || (r_j == r_i && r_pend)))
        else $error("sweep index ran past individual");

    // an update never wraps a counter back to zero
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cnt_we && (r_state == pgcc_pkg::ST_SWEEP)) |-> (cnt_wdata != '0))
        else $error("conflict counter wrapped");

    // nothing is accepted during the clearing pass
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pgcc_pkg::ST_CLEAR) |-> (busy && !o_valid))
        else $error("item taken while clearing");
`endif

endmodule
